// ===== sv/tst_pkg.sv =====
// Shared constants, types and state codes for the ternary search table.
package tst_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int ADDR_WIDTH  = $clog2(TABLE_DEPTH);
   localparam int IDX_WIDTH   = 10;
   localparam int DATA_WIDTH  = 32;
   localparam int POS_WIDTH   = IDX_WIDTH + 2;

   localparam int DIV_IN_WIDTH   = IDX_WIDTH + 1;
   localparam int DIV_SHIFT      = DIV_IN_WIDTH + 1;
   localparam int DIV_RECIP      = (2 ** DIV_SHIFT + 2) / 3;
   localparam int DIV_PROD_WIDTH = DIV_IN_WIDTH + DIV_SHIFT;

   localparam logic KIND_WRITE  = 1'b0;
   localparam logic KIND_SEARCH = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PROBE,
      ST_SECOND,
      ST_READ1,
      ST_READ2,
      ST_DONE
   } tst_state_type;

   typedef struct packed {
      logic                         wr_en;
      logic [ADDR_WIDTH-1:0]        wr_addr;
      logic signed [DATA_WIDTH-1:0] wr_data;
      logic [ADDR_WIDTH-1:0]        rd_addr;
   } tst_mem_req_type;

endpackage

// ===== sv/ternary_search_table.sv =====
// Top level of the ternary search table: sequencer and table memory.
// A write request stores one signed 32-bit entry and returns nothing. A search
// request runs a ternary search over the inclusive index range (last index
// clamped to the table) and returns one response: found and the matching
// position, or found low and position zero. Each round places the first probe,
// then the second, then reads the first entry; it reads the second entry too
// unless the first probe matches or the key lies below it. The round time is
// bounded by the one table read port and by the shared divide-by-three unit
// that places both probes. No request is taken while a search runs or its
// response waits. The table is not cleared at reset; only entries written
// since reset may be searched.
module ternary_search_table (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_kind,
   input  logic [tst_pkg::IDX_WIDTH-1:0]          req_entry_index,
   input  logic signed [tst_pkg::DATA_WIDTH-1:0]  req_entry_value,
   input  logic signed [tst_pkg::DATA_WIDTH-1:0]  req_search_key,
   input  logic [tst_pkg::IDX_WIDTH-1:0]          req_first_index,
   input  logic [tst_pkg::IDX_WIDTH-1:0]          req_last_index,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_found,
   output logic [tst_pkg::IDX_WIDTH-1:0]          rsp_position
);

   tst_pkg::tst_mem_req_type              mem_req;
   logic [tst_pkg::DATA_WIDTH-1:0]        rd_data;

   tst_seq u_seq (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_entry_index (req_entry_index),
      .req_entry_value (req_entry_value),
      .req_search_key  (req_search_key),
      .req_first_index (req_first_index),
      .req_last_index  (req_last_index),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_found       (rsp_found),
      .rsp_position    (rsp_position),
      .mem_req         (mem_req),
      .rd_data         ($signed(rd_data))
   );

   tst_ram #(
      .DEPTH (tst_pkg::TABLE_DEPTH),
      .WIDTH (tst_pkg::DATA_WIDTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_req.wr_en),
      .wr_addr (mem_req.wr_addr),
      .wr_data (mem_req.wr_data),
      .rd_addr (mem_req.rd_addr),
      .rd_data (rd_data)
   );

endmodule

// ===== sv/tst_ram.sv =====
// Single-port-write, single-port-read table memory with registered read data.
module tst_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 32,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/tst_div3.sv =====
// Divide-by-three unit: reciprocal multiply and shift, floored quotient.
module tst_div3 (
   input  logic [tst_pkg::DIV_IN_WIDTH-1:0] dividend,
   output logic [tst_pkg::DIV_IN_WIDTH-1:0] quotient
);

   logic [tst_pkg::DIV_PROD_WIDTH-1:0] product;

   assign product  = tst_pkg::DIV_PROD_WIDTH'(dividend)
                   * tst_pkg::DIV_PROD_WIDTH'(tst_pkg::DIV_RECIP);
   assign quotient = tst_pkg::DIV_IN_WIDTH'(product >> tst_pkg::DIV_SHIFT);

endmodule

// ===== sv/tst_seq.sv =====
// Search sequencer: range registers, probe computation, compares and result register.
module tst_seq (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_kind,
   input  logic [tst_pkg::IDX_WIDTH-1:0]          req_entry_index,
   input  logic signed [tst_pkg::DATA_WIDTH-1:0]  req_entry_value,
   input  logic signed [tst_pkg::DATA_WIDTH-1:0]  req_search_key,
   input  logic [tst_pkg::IDX_WIDTH-1:0]          req_first_index,
   input  logic [tst_pkg::IDX_WIDTH-1:0]          req_last_index,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_found,
   output logic [tst_pkg::IDX_WIDTH-1:0]          rsp_position,
   output tst_pkg::tst_mem_req_type               mem_req,
   input  logic signed [tst_pkg::DATA_WIDTH-1:0]  rd_data
);

   tst_pkg::tst_state_type                 state_ff, state_in;
   logic signed [tst_pkg::POS_WIDTH-1:0]   lo_ff, lo_in;
   logic signed [tst_pkg::POS_WIDTH-1:0]   hi_ff, hi_in;
   logic signed [tst_pkg::DATA_WIDTH-1:0]  key_ff, key_in;
   logic [tst_pkg::IDX_WIDTH-1:0]          p1_ff, p1_in;
   logic [tst_pkg::IDX_WIDTH-1:0]          p2_ff, p2_in;
   logic                                   found_ff, found_in;
   logic [tst_pkg::IDX_WIDTH-1:0]          position_ff, position_in;

   logic                                   accept;
   logic [tst_pkg::IDX_WIDTH-1:0]          len;
   logic [tst_pkg::DIV_IN_WIDTH-1:0]       div_x;
   logic [tst_pkg::DIV_IN_WIDTH-1:0]       div_q;
   logic [tst_pkg::IDX_WIDTH-1:0]          probe;
   logic signed [tst_pkg::POS_WIDTH-1:0]   p1_s;
   logic signed [tst_pkg::POS_WIDTH-1:0]   p2_s;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != tst_pkg::ST_IDLE);
   assign rsp_valid = (state_ff == tst_pkg::ST_DONE);
   assign rsp_found    = found_ff;
   assign rsp_position = position_ff;

   assign len   = tst_pkg::IDX_WIDTH'(hi_ff - lo_ff);
   assign div_x = (state_ff == tst_pkg::ST_SECOND) ? {len, 1'b0} : {1'b0, len};
   assign probe = tst_pkg::IDX_WIDTH'(lo_ff) + tst_pkg::IDX_WIDTH'(div_q);
   assign p1_s  = $signed({2'b00, p1_ff});
   assign p2_s  = $signed({2'b00, p2_ff});

   tst_div3 u_div3 (
      .dividend (div_x),
      .quotient (div_q)
   );

   always_comb begin
      mem_req.wr_en   = accept && (req_kind == tst_pkg::KIND_WRITE)
                     && (32'(req_entry_index) < tst_pkg::TABLE_DEPTH);
      mem_req.wr_addr = tst_pkg::ADDR_WIDTH'(req_entry_index);
      mem_req.wr_data = req_entry_value;
      mem_req.rd_addr = (state_ff == tst_pkg::ST_SECOND)
                      ? tst_pkg::ADDR_WIDTH'(p1_ff) : tst_pkg::ADDR_WIDTH'(p2_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tst_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      key_ff      <= key_in;
      p1_ff       <= p1_in;
      p2_ff       <= p2_in;
      found_ff    <= found_in;
      position_ff <= position_in;
   end

   always_comb begin
      state_in    = state_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      key_in      = key_ff;
      p1_in       = p1_ff;
      p2_in       = p2_ff;
      found_in    = found_ff;
      position_in = position_ff;
      case (state_ff)
         tst_pkg::ST_IDLE: begin
            if (accept && (req_kind == tst_pkg::KIND_SEARCH)) begin
               key_in = req_search_key;
               lo_in  = $signed({2'b00, req_first_index});
               if (32'(req_last_index) > tst_pkg::TABLE_DEPTH - 1) begin
                  hi_in = tst_pkg::POS_WIDTH'(tst_pkg::TABLE_DEPTH - 1);
               end else begin
                  hi_in = $signed({2'b00, req_last_index});
               end
               state_in = tst_pkg::ST_PROBE;
            end
         end
         tst_pkg::ST_PROBE: begin
            if (lo_ff > hi_ff) begin
               found_in    = 1'b0;
               position_in = '0;
               state_in    = tst_pkg::ST_DONE;
            end else begin
               p1_in    = probe;
               state_in = tst_pkg::ST_SECOND;
            end
         end
         tst_pkg::ST_SECOND: begin
            p2_in    = probe;
            state_in = tst_pkg::ST_READ1;
         end
         tst_pkg::ST_READ1: begin
            if (rd_data == key_ff) begin
               found_in    = 1'b1;
               position_in = p1_ff;
               state_in    = tst_pkg::ST_DONE;
            end else if (key_ff < rd_data) begin
               hi_in    = p1_s - tst_pkg::POS_WIDTH'(1);
               state_in = tst_pkg::ST_PROBE;
            end else begin
               state_in = tst_pkg::ST_READ2;
            end
         end
         tst_pkg::ST_READ2: begin
            if (rd_data == key_ff) begin
               found_in    = 1'b1;
               position_in = p2_ff;
               state_in    = tst_pkg::ST_DONE;
            end else if (key_ff > rd_data) begin
               lo_in    = p2_s + tst_pkg::POS_WIDTH'(1);
               state_in = tst_pkg::ST_PROBE;
            end else begin
               lo_in    = p1_s + tst_pkg::POS_WIDTH'(1);
               hi_in    = p2_s - tst_pkg::POS_WIDTH'(1);
               state_in = tst_pkg::ST_PROBE;
            end
         end
         tst_pkg::ST_DONE: begin
            if (!rsp_stall) begin
               state_in = tst_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tst_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ===== sv/tst_checker.sv =====
// Port-level checks for the ternary search table and their binding.
module tst_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_stall,
   input logic                               req_kind,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic                               rsp_found,
   input logic [tst_pkg::IDX_WIDTH-1:0]      rsp_position
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_found)
                                 && $stable(rsp_position))
      else $error("response changed while stalled");

   a_busy_on_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request taken while response pending");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_position == '0)
      else $error("miss with nonzero position");

   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_kind == tst_pkg::KIND_WRITE |=> !rsp_valid)
      else $error("write request produced a response");

   a_search_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_kind == tst_pkg::KIND_SEARCH
      |=> req_stall && !rsp_valid)
      else $error("search did not hold off requests");

endmodule

bind ternary_search_table tst_checker u_tst_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .req_kind     (req_kind),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_found    (rsp_found),
   .rsp_position (rsp_position)
);
